[rtl/afbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package afbd_pkg;
    localparam int MAX_LEVELS     = 3;
    localparam int NUM_LEVELS_DEF = 3;
    localparam int EXP_DEPTH_DEF  = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam int EXT_W    = 13;
    localparam int STRIDE_W = 9;
    localparam int CELL_W   = 13;
    localparam int POS_W    = 12;
    localparam int LVL_W    = 2;
    localparam int CLS_W    = 8;
    localparam int SCORE_W  = 16;
    localparam int LOGIT_W  = 16;
    localparam int COORD_W  = 20;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CELL_W-1:0] MAX_CELLS = CELL_W'(4096);
    localparam logic signed [32:0] COORD_MAX = 33'sd524287;
    localparam logic signed [32:0] COORD_MIN = -33'sd524288;

    localparam logic [EXT_W-1:0]    RST_EXTENT  = EXT_W'(640);
    localparam logic [STRIDE_W-1:0] RST_STRIDE0 = STRIDE_W'(8);
    localparam logic [STRIDE_W-1:0] RST_STRIDE1 = STRIDE_W'(16);
    localparam logic [STRIDE_W-1:0] RST_STRIDE2 = STRIDE_W'(32);
    localparam logic [CLS_W-1:0]    RST_CLASSES = CLS_W'(80);
    localparam logic [15:0]         RST_THR     = 16'd19661;
    localparam logic [15:0]         RST_INV     = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_EXTENT = 3'd0,
        REG_STRIDE0     = 3'd1,
        REG_STRIDE1     = 3'd2,
        REG_STRIDE2     = 3'd3,
        REG_CLASS_COUNT = 3'd4,
        REG_PROB_THR    = 3'd5,
        REG_INV_SCALE   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [EXT_W-1:0]                     grid_extent;
        logic [MAX_LEVELS-1:0][STRIDE_W-1:0]  stride;
        logic [CLS_W-1:0]                     class_count;
        logic [15:0]                          prob_thr;
        logic [15:0]                          inv_scale;
    } t_cfg;

    typedef struct packed {
        logic                       is_hdr;
        logic [POS_W-1:0]           col;
        logic [POS_W-1:0]           row;
        logic [STRIDE_W-1:0]        stride;
        logic [CLS_W-1:0]           cls_id;
        logic signed [LOGIT_W-1:0]  a;
        logic signed [LOGIT_W-1:0]  b;
        logic signed [LOGIT_W-1:0]  c;
        logic signed [LOGIT_W-1:0]  d;
        logic [SCORE_W-1:0]         e;
    } t_item;
endpackage
`default_nettype wire

[rtl/afbd_cells.sv]
`timescale 1ns / 1ps
`default_nettype none
module afbd_cells #(
    parameter int NUM_LEVELS = afbd_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                                                   i_clk,
    input  wire logic                                                   i_rst_n,
    input  wire logic                                                   i_start,
    input  wire logic [afbd_pkg::EXT_W-1:0]                             i_extent,
    input  wire logic [afbd_pkg::MAX_LEVELS-1:0][afbd_pkg::STRIDE_W-1:0] i_stride,
    output logic [afbd_pkg::MAX_LEVELS-1:0][afbd_pkg::CELL_W-1:0]       o_cells,
    output logic                                                        o_busy
);
    import afbd_pkg::*;

    localparam logic [3:0] TOP_BIT = 4'(EXT_W - 1);

    logic                                  r_run;
    logic [LVL_W-1:0]                      r_lvl;
    logic [3:0]                            r_bit;
    logic [STRIDE_W-1:0]                   r_rem;
    logic [EXT_W-1:0]                      r_quo;
    logic [MAX_LEVELS-1:0][CELL_W-1:0]     r_cells;

    logic [STRIDE_W:0]    trial;
    logic                 ge;
    logic [STRIDE_W-1:0]  n_rem;
    logic [EXT_W-1:0]     n_quo;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, i_extent[r_bit]};
        ge    = trial >= {1'b0, i_stride[r_lvl]};
        n_rem = ge ? STRIDE_W'(trial - {1'b0, i_stride[r_lvl]}) : STRIDE_W'(trial);
        n_quo = {r_quo[EXT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_run <= 1'b1;
            r_lvl <= '0;
            r_bit <= TOP_BIT;
            r_rem <= '0;
            r_quo <= '0;
            if (!i_rst_n) begin
                r_cells <= '0;
            end
        end else if (r_run) begin
            if (r_bit == 4'd0) begin
                r_cells[r_lvl] <= (n_quo > MAX_CELLS) ? MAX_CELLS : n_quo;
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= TOP_BIT;
                if (r_lvl == LVL_W'(NUM_LEVELS - 1)) begin
                    r_run <= 1'b0;
                end else begin
                    r_lvl <= r_lvl + 1'b1;
                end
            end else begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    assign o_cells = r_cells;
    assign o_busy  = r_run;
endmodule
`default_nettype wire

[rtl/afbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module afbd_front #(
    parameter int NUM_LEVELS = afbd_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                                               i_clk,
    input  wire logic                                               i_rst_n,
    input  wire afbd_pkg::t_cfg                                     i_cfg,
    input  wire logic [afbd_pkg::MAX_LEVELS-1:0][afbd_pkg::CELL_W-1:0] i_cells,
    input  wire logic                                               i_cells_busy,
    input  wire logic                                               i_valid,
    output logic                                                    o_stall,
    input  wire logic                                               i_func,
    input  wire logic                                               i_frame_start,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]                i_offset_x,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]                i_offset_y,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]                i_log_w,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]                i_log_h,
    input  wire logic [afbd_pkg::SCORE_W-1:0]                       i_objectness,
    input  wire logic [afbd_pkg::SCORE_W-1:0]                       i_class_score,
    input  wire logic                                               i_full,
    output logic                                                    o_push,
    output afbd_pkg::t_item                                         o_item
);
    import afbd_pkg::*;

    logic [POS_W-1:0] r_col, r_row;
    logic [LVL_W-1:0] r_lvl;
    logic [CLS_W-1:0] r_cls;

    logic [POS_W-1:0]      col_c, row_c, n_col, n_row;
    logic [LVL_W-1:0]      lvl_c, n_lvl;
    logic [CLS_W-1:0]      n_cls;
    logic [MAX_LEVELS-1:0] has;
    logic [CELL_W-1:0]     cells_c;
    logic [POS_W:0]        col1, row1;
    logic                  accept, pass;

    function automatic logic [LVL_W-1:0] next_level(input logic [LVL_W:0] from,
                                                    input logic [MAX_LEVELS-1:0] h);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (h[l]) r = LVL_W'(l);
        end
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (h[l] && (l >= int'(from))) r = LVL_W'(l);
        end
        return r;
    endfunction

    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            has[l] = i_cells[l] != '0;
        end
        col_c   = i_frame_start ? '0 : r_col;
        row_c   = i_frame_start ? '0 : r_row;
        lvl_c   = i_frame_start ? next_level('0, has) : r_lvl;
        cells_c = i_cells[lvl_c];
        col1    = {1'b0, col_c} + 1'b1;
        row1    = {1'b0, row_c} + 1'b1;
        pass    = r_cls < i_cfg.class_count;
        n_col   = col_c;
        n_row   = row_c;
        n_lvl   = lvl_c;
        n_cls   = r_cls;
        if (!i_func) begin
            n_cls = '0;
            if (col1 >= cells_c) begin
                n_col = '0;
                if (row1 >= cells_c) begin
                    n_row = '0;
                    n_lvl = next_level({1'b0, lvl_c} + 1'b1, has);
                end else begin
                    n_row = row1[POS_W-1:0];
                end
            end else begin
                n_col = col1[POS_W-1:0];
            end
        end else if (pass) begin
            n_cls = r_cls + 1'b1;
        end
    end

    assign o_stall = i_full || i_cells_busy;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept && (!i_func || pass);

    always_comb begin
        o_item.is_hdr = !i_func;
        o_item.col    = col_c;
        o_item.row    = row_c;
        o_item.stride = i_cfg.stride[lvl_c];
        o_item.cls_id = r_cls;
        o_item.a      = i_offset_x;
        o_item.b      = i_offset_y;
        o_item.c      = i_log_w;
        o_item.d      = i_log_h;
        o_item.e      = i_func ? i_class_score : i_objectness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_lvl <= '0;
            r_cls <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_lvl <= n_lvl;
            r_cls <= n_cls;
        end
    end
endmodule
`default_nettype wire

[rtl/afbd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module afbd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire afbd_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output afbd_pkg::t_item      o_item,
    output logic                 o_empty
);
    import afbd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW:0]   r_wp, r_rp;

    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_item  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[AW-1:0]] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end
endmodule
`default_nettype wire

[rtl/afbd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module afbd_back #(
    parameter int EXP_TABLE_DEPTH = afbd_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire afbd_pkg::t_cfg                       i_cfg,
    input  wire afbd_pkg::t_item                      i_item,
    input  wire logic                                 i_empty,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [afbd_pkg::COORD_W-1:0]       o_x_min,
    output logic signed [afbd_pkg::COORD_W-1:0]       o_y_min,
    output logic signed [afbd_pkg::COORD_W-1:0]       o_x_max,
    output logic signed [afbd_pkg::COORD_W-1:0]       o_y_max,
    output logic [afbd_pkg::CLS_W-1:0]                o_class_id,
    output logic [afbd_pkg::SCORE_W-1:0]              o_confidence
);
    import afbd_pkg::*;

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_YW, S_YH, S_TW, S_TH, S_SH, S_HW, S_HH, S_CX, S_CY,
        S_ELO, S_EHI, S_ESAT
    } t_state;

    function automatic logic [17:0] pow2_entry(input int i);
        logic [63:0] u, z, acc;
        u   = (64'(i) << 16) / EXP_TABLE_DEPTH;
        z   = (u * 64'd45426) >> 16;
        acc = 64'd65536;
        acc = 64'd65536 + (acc * z) / 64'd393216;
        acc = 64'd65536 + (acc * z) / 64'd327680;
        acc = 64'd65536 + (acc * z) / 64'd262144;
        acc = 64'd65536 + (acc * z) / 64'd196608;
        acc = 64'd65536 + (acc * z) / 64'd131072;
        acc = 64'd65536 + (acc * z) / 64'd65536;
        return 18'(acc);
    endfunction

    function automatic logic [28:0] exp_shift(input logic [17:0] ent,
                                              input logic signed [5:0] n);
        logic [28:0] w;
        logic [5:0]  m;
        w = {11'b0, ent};
        m = 6'(-n);
        if (n >= 0) return w << n[3:0];
        return w >> m[3:0];
    endfunction

    function automatic logic [IDX_W-1:0] tab_idx(input logic signed [21:0] y);
        return IDX_W'((32'(y[15:0]) * EXP_TABLE_DEPTH) >> 16);
    endfunction

    logic [17:0] exp_tab [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
        assign exp_tab[g] = pow2_entry(g);
    end

    t_state                  r_state;
    t_item                   r_item;
    logic [SCORE_W-1:0]      r_obj;
    logic [3:0][COORD_W-1:0] r_box;
    logic signed [21:0]      r_yw, r_yh;
    logic [17:0]             r_tab;
    logic [28:0]             r_expw, r_exph;
    logic [36:0]             r_hw, r_hh;
    logic signed [39:0]      r_cx, r_cy;
    logic [1:0]              r_e;
    logic [35:0]             r_plo;
    logic signed [56:0]      r_sum;
    logic                    r_ovalid;

    logic                    out_free;
    logic                    hit;
    logic [IDX_W-1:0]        tab_addr;
    logic [31:0]             prod;
    logic signed [40:0]      v;
    logic signed [37:0]      hi;
    logic signed [32:0]      q;
    logic signed [25:0]      base;

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty && (i_item.is_hdr || out_free);
    assign tab_addr = (r_state == S_TH) ? tab_idx(r_yh) : tab_idx(r_yw);
    assign prod     = r_obj * i_item.e;
    assign hit      = o_pop && !i_item.is_hdr && (prod > {i_cfg.prob_thr, 16'b0});

    always_comb begin
        unique case (r_e)
            2'd0:    v = 41'(r_cx) - $signed({4'b0, r_hw});
            2'd1:    v = 41'(r_cy) - $signed({4'b0, r_hh});
            2'd2:    v = 41'(r_cx) + $signed({4'b0, r_hw});
            default: v = 41'(r_cy) + $signed({4'b0, r_hh});
        endcase
        hi   = $signed(v[40:20]) * $signed({1'b0, i_cfg.inv_scale});
        q    = 33'(r_sum >>> 24);
        base = 26'(r_state == S_CY ? r_item.b : r_item.a)
             + $signed({2'b0, (r_state == S_CY ? r_item.row : r_item.col), 12'b0});
    end

    always_ff @(posedge i_clk) begin
        r_tab <= exp_tab[tab_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_obj    <= '0;
            r_box    <= '0;
            r_ovalid <= 1'b0;
            r_e      <= '0;
        end else begin
            if (hit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_item.is_hdr) begin
                            r_item  <= i_item;
                            r_obj   <= i_item.e;
                            r_state <= S_YW;
                        end else if (hit) begin
                            o_x_min      <= r_box[0];
                            o_y_min      <= r_box[1];
                            o_x_max      <= r_box[2];
                            o_y_max      <= r_box[3];
                            o_class_id   <= i_item.cls_id;
                            o_confidence <= prod[31:16];
                        end
                    end
                end
                S_YW: begin
                    r_yw    <= 22'((33'(r_item.c) * 33'sd47274) >>> 11);
                    r_state <= S_YH;
                end
                S_YH: begin
                    r_yh    <= 22'((33'(r_item.d) * 33'sd47274) >>> 11);
                    r_state <= S_TW;
                end
                S_TW: r_state <= S_TH;
                S_TH: begin
                    r_expw  <= exp_shift(r_tab, r_yw[21:16]);
                    r_state <= S_SH;
                end
                S_SH: begin
                    r_exph  <= exp_shift(r_tab, r_yh[21:16]);
                    r_state <= S_HW;
                end
                S_HW: begin
                    r_hw    <= 37'((38'(r_expw) * 38'(r_item.stride)) >> 1);
                    r_state <= S_HH;
                end
                S_HH: begin
                    r_hh    <= 37'((38'(r_exph) * 38'(r_item.stride)) >> 1);
                    r_state <= S_CX;
                end
                S_CX: begin
                    r_cx    <= (40'(base) * 40'($signed({1'b0, r_item.stride}))) <<< 4;
                    r_state <= S_CY;
                end
                S_CY: begin
                    r_cy    <= (40'(base) * 40'($signed({1'b0, r_item.stride}))) <<< 4;
                    r_e     <= '0;
                    r_state <= S_ELO;
                end
                S_ELO: begin
                    r_plo   <= v[19:0] * i_cfg.inv_scale;
                    r_state <= S_EHI;
                end
                S_EHI: begin
                    r_sum   <= (57'(hi) <<< 20) + $signed({21'b0, r_plo})
                             + 57'sd8388608;
                    r_state <= S_ESAT;
                end
                S_ESAT: begin
                    if (q > COORD_MAX)      r_box[r_e] <= COORD_MAX[COORD_W-1:0];
                    else if (q < COORD_MIN) r_box[r_e] <= COORD_MIN[COORD_W-1:0];
                    else                    r_box[r_e] <= q[COORD_W-1:0];
                    r_e     <= r_e + 1'b1;
                    r_state <= (r_e == 2'd3) ? S_IDLE : S_ELO;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

[rtl/anchor_free_box_decoder_core.sv]
// Class score items pass queue and output registers; one per cycle if not stalled.
// Header items: the box unit takes steps of at most one multiply, 3 per edge.
// Class items queue behind a header and wait until its box is finished.
// Grid cell counts are recomputed by a serial divider, one level after another,
// after reset and after each configuration write; no item is taken meanwhile.
// Reset (synchronous, active low) restores register defaults and clears position.
`timescale 1ns / 1ps
`default_nettype none
module anchor_free_box_decoder_core #(
    parameter int NUM_LEVELS      = afbd_pkg::NUM_LEVELS_DEF,
    parameter int EXP_TABLE_DEPTH = afbd_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [afbd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [afbd_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_func,
    input  wire logic                                  i_frame_start,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]   i_offset_x,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]   i_offset_y,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]   i_log_w,
    input  wire logic signed [afbd_pkg::LOGIT_W-1:0]   i_log_h,
    input  wire logic [afbd_pkg::SCORE_W-1:0]          i_objectness,
    input  wire logic [afbd_pkg::SCORE_W-1:0]          i_class_score,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [afbd_pkg::COORD_W-1:0]        o_x_min,
    output logic signed [afbd_pkg::COORD_W-1:0]        o_y_min,
    output logic signed [afbd_pkg::COORD_W-1:0]        o_x_max,
    output logic signed [afbd_pkg::COORD_W-1:0]        o_y_max,
    output logic [afbd_pkg::CLS_W-1:0]                 o_class_id,
    output logic [afbd_pkg::SCORE_W-1:0]               o_confidence
);
    import afbd_pkg::*;

    logic [EXT_W-1:0]                    r_extent;
    logic [MAX_LEVELS-1:0][STRIDE_W-1:0] r_stride;
    logic [CLS_W-1:0]                    r_classes;
    logic [15:0]                         r_thr, r_inv;

    t_cfg                              cfg;
    logic [MAX_LEVELS-1:0][CELL_W-1:0] cells;
    logic                              cells_busy;
    logic                              push, pop, full, empty;
    t_item                             push_item, pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent    <= RST_EXTENT;
            r_stride[0] <= RST_STRIDE0;
            r_stride[1] <= RST_STRIDE1;
            r_stride[2] <= RST_STRIDE2;
            r_classes   <= RST_CLASSES;
            r_thr       <= RST_THR;
            r_inv       <= RST_INV;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GRID_EXTENT: r_extent    <= i_cfg_data[EXT_W-1:0];
                REG_STRIDE0:     r_stride[0] <= i_cfg_data[STRIDE_W-1:0];
                REG_STRIDE1:     r_stride[1] <= i_cfg_data[STRIDE_W-1:0];
                REG_STRIDE2:     r_stride[2] <= i_cfg_data[STRIDE_W-1:0];
                REG_CLASS_COUNT: r_classes   <= i_cfg_data[CLS_W-1:0];
                REG_PROB_THR:    r_thr       <= i_cfg_data;
                REG_INV_SCALE:   r_inv       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero stride behaves as one
    always_comb begin
        cfg.grid_extent = r_extent;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            cfg.stride[l] = (r_stride[l] == '0) ? STRIDE_W'(1) : r_stride[l];
        end
        cfg.class_count = r_classes;
        cfg.prob_thr    = r_thr;
        cfg.inv_scale   = r_inv;
    end

    afbd_cells #(.NUM_LEVELS(NUM_LEVELS)) u_cells (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_extent (cfg.grid_extent),
        .i_stride (cfg.stride),
        .o_cells  (cells),
        .o_busy   (cells_busy)
    );

    afbd_front #(.NUM_LEVELS(NUM_LEVELS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cells       (cells),
        .i_cells_busy  (cells_busy),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_frame_start (i_frame_start),
        .i_offset_x    (i_offset_x),
        .i_offset_y    (i_offset_y),
        .i_log_w       (i_log_w),
        .i_log_h       (i_log_h),
        .i_objectness  (i_objectness),
        .i_class_score (i_class_score),
        .i_full        (full),
        .o_push        (push),
        .o_item        (push_item)
    );

    afbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty)
    );

    afbd_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (pop_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_x_min      (o_x_min),
        .o_y_min      (o_y_min),
        .o_x_max      (o_x_max),
        .o_y_max      (o_y_max),
        .o_class_id   (o_class_id),
        .o_confidence (o_confidence)
    );
endmodule
`default_nettype wire

[tb/anchor_free_box_decoder_core_tb.sv]
`timescale 1ns / 1ps
module anchor_free_box_decoder_core_tb;
    import afbd_pkg::*;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam bit KIND_HDR = 1'b0;
    localparam bit KIND_CLS = 1'b1;

    typedef struct packed {
        logic func;
        logic frame_start;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] lw;
        logic [15:0] lh;
        logic [15:0] obj;
        logic [15:0] score;
    } t_req;

    typedef struct packed {
        logic [19:0] x0;
        logic [19:0] y0;
        logic [19:0] x1;
        logic [19:0] y1;
        logic [7:0]  cls;
        logic [15:0] conf;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_func = 1'b0, i_frame_start = 1'b0;
    logic signed [15:0] i_offset_x = '0, i_offset_y = '0, i_log_w = '0, i_log_h = '0;
    logic [15:0] i_objectness = '0, i_class_score = '0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [19:0] o_x_min, o_y_min, o_x_max, o_y_max;
    logic [7:0] o_class_id;
    logic [15:0] o_confidence;

    anchor_free_box_decoder_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    int unsigned m_ext, m_str[3], m_ncls, m_thr, m_inv;
    int unsigned m_col, m_row, m_lvl, m_cidx, m_obj;
    logic [19:0] m_box[4];

    t_req pending_reqs[$];
    t_box expected_boxes[$];
    int errors = 0;
    int idle_cycles = 0;
    bit running = 1'b0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int unsigned stride_at(int unsigned l);
        return (m_str[l] == 0) ? 1 : m_str[l];
    endfunction

    function automatic int unsigned cells_at(int unsigned l);
        int unsigned n;
        n = m_ext / stride_at(l);
        return (n > 4096) ? 4096 : n;
    endfunction

    function automatic int unsigned first_level_from(int unsigned from);
        for (int unsigned l = from; l < 3; l++) if (cells_at(l) > 0) return l;
        for (int unsigned l = 0; l < 3; l++) if (cells_at(l) > 0) return l;
        return 0;
    endfunction

    function automatic longint unsigned pow2_frac(longint unsigned u);
        longint unsigned z, acc;
        z = (u * 45426) >> 16;
        acc = 65536;
        for (int k = 6; k >= 1; k--) acc = 65536 + (acc * z) / (longint'(k) << 16);
        return acc;
    endfunction

    function automatic longint unsigned exp_q16(logic signed [15:0] x);
        longint y, n;
        longint unsigned f, idx, p;
        y = fshr(longint'(x) * 47274, 11);
        n = fshr(y, 16);
        f = y - n * 65536;
        idx = (f * DEPTH) >> 16;
        p = pow2_frac((idx << 16) / DEPTH);
        return (n >= 0) ? (p << n) : (p >> (-n));
    endfunction

    function automatic logic [19:0] edge_px(longint v16);
        longint v;
        v = fshr(v16 * longint'(m_inv) + (longint'(1) << 23), 24);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    task automatic decode_request(input t_req r);
        longint s, cx, cy, hw, hh;
        longint unsigned prod;
        int unsigned n;
        t_box b;
        if (r.frame_start) begin
            m_col = 0; m_row = 0; m_lvl = first_level_from(0);
        end
        if (r.func == KIND_HDR) begin
            s = stride_at(m_lvl);
            cx = (longint'($signed(r.ox)) + (longint'(m_col) << 12)) * s * 16;
            cy = (longint'($signed(r.oy)) + (longint'(m_row) << 12)) * s * 16;
            hw = (exp_q16(r.lw) * s) >> 1;
            hh = (exp_q16(r.lh) * s) >> 1;
            m_box[0] = edge_px(cx - hw); m_box[1] = edge_px(cy - hh);
            m_box[2] = edge_px(cx + hw); m_box[3] = edge_px(cy + hh);
            m_obj = r.obj; m_cidx = 0;
            n = cells_at(m_lvl);
            m_col++;
            if (m_col >= n) begin
                m_col = 0; m_row++;
                if (m_row >= n) begin
                    m_row = 0; m_lvl = first_level_from(m_lvl + 1);
                end
            end
        end else if (m_cidx < m_ncls) begin
            prod = longint'(m_obj) * r.score;
            b.cls = m_cidx[7:0];
            m_cidx++;
            if (prod > (longint'(m_thr) << 16)) begin
                b.x0 = m_box[0]; b.y0 = m_box[1]; b.x1 = m_box[2]; b.y1 = m_box[3];
                b.conf = prod[31:16];
                expected_boxes.insert(expected_boxes.size(), b);
            end
        end
    endtask

    // driver: bursts and gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (i_valid) begin
                    decode_request(pending_reqs.pop_front());
                end
                if (pending_reqs.size() > 0 && running && gap_left == 0) begin
                    t_req r;
                    r = pending_reqs[0];
                    i_valid <= 1'b1;
                    i_func <= r.func; i_frame_start <= r.frame_start;
                    i_offset_x <= r.ox; i_offset_y <= r.oy;
                    i_log_w <= r.lw; i_log_h <= r.lh;
                    i_objectness <= r.obj; i_class_score <= r.score;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else burst_left--;
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // receiver stall pattern and checker
    int stall_mode = 0;
    always @(posedge i_clk) begin
        t_box e;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_boxes.size() == 0) begin
                    $error("unexpected box cls=%0d", o_class_id);
                    errors++;
                end else begin
                    e = expected_boxes.pop_front();
                    if (o_x_min !== e.x0) begin $error("x_min exp %0h got %0h", e.x0, o_x_min); errors++; end
                    if (o_y_min !== e.y0) begin $error("y_min exp %0h got %0h", e.y0, o_y_min); errors++; end
                    if (o_x_max !== e.x1) begin $error("x_max exp %0h got %0h", e.x1, o_x_max); errors++; end
                    if (o_y_max !== e.y1) begin $error("y_max exp %0h got %0h", e.y1, o_y_max); errors++; end
                    if (o_class_id !== e.cls) begin $error("class_id exp %0d got %0d", e.cls, o_class_id); errors++; end
                    if (o_confidence !== e.conf) begin $error("confidence exp %0d got %0d", e.conf, o_confidence); errors++; end
                end
            end
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_GRID_EXTENT: m_ext = val & 16'h1FFF;
            REG_STRIDE0: m_str[0] = val & 9'h1FF;
            REG_STRIDE1: m_str[1] = val & 9'h1FF;
            REG_STRIDE2: m_str[2] = val & 9'h1FF;
            REG_CLASS_COUNT: m_ncls = val & 8'hFF;
            REG_PROB_THR: m_thr = val & 16'hFFFF;
            default: m_inv = val & 16'hFFFF;
        endcase
    endtask

    function automatic t_req rand_hdr(bit fs);
        t_req r;
        r.func = KIND_HDR; r.frame_start = fs;
        r.ox = $urandom; r.oy = $urandom;
        r.lw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 32767)) - 16384);
        r.lh = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 32767)) - 16384);
        r.obj = $urandom; r.score = $urandom;
        return r;
    endfunction

    function automatic t_req rand_cls(bit fs);
        t_req r;
        r = rand_hdr(fs);
        r.func = KIND_CLS;
        return r;
    endfunction

    task automatic run_and_drain();
        running = 1'b1;
        wait (pending_reqs.size() == 0 && !i_valid);
        wait (expected_boxes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        running = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int ncls);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_reqs.insert(pending_reqs.size(),
                                    $urandom_range(0, 1) ? rand_cls($urandom_range(0, 7) == 0)
                                                         : rand_hdr($urandom_range(0, 7) == 0));
                k++;
            end else begin
                pending_reqs.insert(pending_reqs.size(), rand_hdr($urandom_range(0, 15) == 0));
                k++;
                for (int c = 0; c < ncls + $urandom_range(0, 1); c++) begin
                    pending_reqs.insert(pending_reqs.size(), rand_cls(1'b0));
                    k++;
                end
            end
        end
    endtask

    initial begin
        t_req r;
        m_ext = 640; m_str[0] = 8; m_str[1] = 16; m_str[2] = 32;
        m_ncls = 80; m_thr = 19661; m_inv = 4096;
        m_col = 0; m_row = 0; m_lvl = 0; m_cidx = 0; m_obj = 0;
        for (int i = 0; i < 4; i++) m_box[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (100) @(posedge i_clk);

        // directed: class before header, extremes, extra classes
        write_reg(REG_CLASS_COUNT, 3);
        write_reg(REG_PROB_THR, 0);
        repeat (100) @(posedge i_clk);
        r = rand_cls(1'b0); r.score = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
        r = rand_hdr(1'b1); r.ox = 16'h7FFF; r.oy = 16'h8000; r.lw = 16'h7FFF; r.lh = 16'h8000;
        r.obj = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
        r = rand_cls(1'b0); r.score = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
        r.score = 16'h0000; pending_reqs.insert(pending_reqs.size(), r);
        r.score = 16'h8000; pending_reqs.insert(pending_reqs.size(), r);
        r.score = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
        r = rand_hdr(1'b0); r.ox = 0; r.oy = 0; r.lw = 0; r.lh = 0; r.obj = 0;
        pending_reqs.insert(pending_reqs.size(), r);
        r = rand_cls(1'b1); r.score = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
        run_and_drain();

        // default-ish random
        random_phase(100, 3);
        run_and_drain();

        // tiny grid: level wrap, empty level, zero stride
        write_reg(REG_GRID_EXTENT, 2);
        write_reg(REG_STRIDE0, 0);
        write_reg(REG_STRIDE1, 256);
        write_reg(REG_STRIDE2, 1);
        write_reg(REG_INV_SCALE, 65535);
        write_reg(REG_PROB_THR, 16384);
        write_reg(REG_CLASS_COUNT, 1);
        repeat (100) @(posedge i_clk);
        random_phase(100, 1);
        run_and_drain();

        // extremes of extent and strides
        write_reg(REG_GRID_EXTENT, 4096);
        write_reg(REG_STRIDE0, 1);
        write_reg(REG_STRIDE1, 255);
        write_reg(REG_STRIDE2, 0);
        write_reg(REG_INV_SCALE, 0);
        write_reg(REG_PROB_THR, 65535);
        write_reg(REG_CLASS_COUNT, 255);
        repeat (100) @(posedge i_clk);
        random_phase(40, 4);
        run_and_drain();

        write_reg(REG_GRID_EXTENT, 8191);
        write_reg(REG_STRIDE1, 1);
        write_reg(REG_INV_SCALE, 2048);
        write_reg(REG_PROB_THR, 1000);
        write_reg(REG_CLASS_COUNT, 2);
        repeat (100) @(posedge i_clk);
        random_phase(160, 2);
        run_and_drain();

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[filelist.f]
rtl/afbd_pkg.sv
rtl/afbd_cells.sv
rtl/afbd_front.sv
rtl/afbd_fifo.sv
rtl/afbd_back.sv
rtl/anchor_free_box_decoder_core.sv
tb/anchor_free_box_decoder_core_tb.sv
